// ===== sv/sjsm_pkg.sv =====
// Package for the sparse Jensen-Shannon merge unit.
// Holds widths, command and status types and the state encoding.
// No dependencies; every other file of the block uses it.
package sjsm_pkg;

    // Field and datapath widths.
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 48;
    localparam int FRAC_W     = 24;
    localparam int OPND_W     = VAL_W + 1;
    localparam int EXP_W      = 6;
    localparam int LOG_W      = EXP_W + FRAC_W;
    localparam int HI_W       = OPND_W - FRAC_W;
    localparam int HP_W       = HI_W + LOG_W;
    localparam int TERM_W     = HP_W + 1;
    localparam int CNT_W      = 5;
    localparam int NORM_STEPS = 6;
    localparam int SQR_STEPS  = FRAC_W;

    // Input record kinds.
    typedef enum logic [1:0] {
        KIND_P_REC = 2'd0,
        KIND_Q_REC = 2'd1,
        KIND_P_END = 2'd2,
        KIND_Q_END = 2'd3
    } t_kind;

    // Merge actions.
    typedef enum logic [1:0] {
        ACT_P    = 2'd0,
        ACT_Q    = 2'd1,
        ACT_BOTH = 2'd2
    } t_act;

    // Operand whose entropy term is being computed.
    typedef enum logic [1:0] {
        OPND_P   = 2'd0,
        OPND_Q   = 2'd1,
        OPND_SUM = 2'd2
    } t_opnd;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD,
        S_NORM,
        S_SQR,
        S_MUL,
        S_SUM,
        S_ACC,
        S_CLEAR,
        S_DIFF,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       norm_load;
        logic       norm_step;
        logic [2:0] norm_idx;
        logic       sqr_step;
        logic       mul;
        logic       sum;
        logic       acc;
        logic       clear;
        logic       diff;
        logic       finish;
        t_opnd      opnd;
        t_act       act;
        logic       j;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic p_full;
        logic q_full;
        logic p_fin;
        logic q_fin;
        logic p_lt_q;
        logic q_lt_p;
        logic out_busy;
    } t_stat;

endpackage

// ===== sv/sjsm_if.sv =====
// Channel interfaces of the sparse Jensen-Shannon merge unit.
// Depends on sjsm_pkg for the field widths.
interface sjsm_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [sjsm_pkg::KEY_W-1:0] feature_key;
    logic [sjsm_pkg::VAL_W-1:0] feature_value;

    modport source (output valid, kind, feature_key, feature_value, input ready);
    modport sink   (input valid, kind, feature_key, feature_value, output ready);
endinterface

interface sjsm_out_if;
    logic        valid;
    logic        ready;
    logic        need_p;
    logic        need_q;
    logic        order_error;
    logic        done_res;
    logic [31:0] divergence;

    modport source (output valid, need_p, need_q, order_error, done_res, divergence,
                    input ready);
    modport sink   (input valid, need_p, need_q, order_error, done_res, divergence,
                    output ready);
endinterface

// ===== sv/sjsm_ctrl.sv =====
// Controller of the sparse Jensen-Shannon merge unit.
// Sequences merges, log2 iterations and accumulation; depends on sjsm_pkg.
module sjsm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sjsm_pkg::t_stat  i_stat,
    output sjsm_pkg::t_cmd   o_cmd
);

    sjsm_pkg::t_state             r_state, n_state;
    sjsm_pkg::t_act               r_act, n_act;
    logic [1:0]                   r_job, n_job;
    logic                         r_j, n_j;
    logic [sjsm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]                   r_merges, n_merges;

    sjsm_pkg::t_opnd job_opnd;
    logic            job_two_j;
    logic            job_first_j;
    logic            job_last;

    // Job table: which operand, which mixture weights, and whether it closes the merge.
    always_comb begin
        unique case (r_act)
            sjsm_pkg::ACT_P: begin
                job_opnd = sjsm_pkg::OPND_P;  job_first_j = 1'b0;
                job_two_j = 1'b1;             job_last = 1'b1;
            end
            sjsm_pkg::ACT_Q: begin
                job_opnd = sjsm_pkg::OPND_Q;  job_first_j = 1'b0;
                job_two_j = 1'b1;             job_last = 1'b1;
            end
            default: begin
                job_two_j = 1'b0;
                unique case (r_job)
                    2'd0: begin
                        job_opnd = sjsm_pkg::OPND_SUM; job_first_j = 1'b1;
                        job_last = 1'b0;
                    end
                    2'd1: begin
                        job_opnd = sjsm_pkg::OPND_P;   job_first_j = 1'b0;
                        job_last = 1'b0;
                    end
                    default: begin
                        job_opnd = sjsm_pkg::OPND_Q;   job_first_j = 1'b0;
                        job_last = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // State register and sequencing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sjsm_pkg::S_IDLE;
            r_act    <= sjsm_pkg::ACT_P;
            r_job    <= 2'd0;
            r_j      <= 1'b0;
            r_cnt    <= '0;
            r_merges <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_act    <= n_act;
            r_job    <= n_job;
            r_j      <= n_j;
            r_cnt    <= n_cnt;
            r_merges <= n_merges;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_job      = r_job;
        n_j        = r_j;
        n_cnt      = r_cnt;
        n_merges   = r_merges;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.opnd = job_opnd;
        o_cmd.act  = r_act;
        o_cmd.j    = r_j;
        o_cmd.norm_idx = r_cnt[2:0];

        unique case (r_state)
            sjsm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_merges   = 2'd0;
                    n_state    = sjsm_pkg::S_DECIDE;
                end
            end
            sjsm_pkg::S_DECIDE: begin
                n_job   = 2'd0;
                n_state = sjsm_pkg::S_LOAD;
                priority if (r_merges == 2'd2) begin
                    n_state = sjsm_pkg::S_DIFF;
                end else if (i_stat.p_full && i_stat.q_full) begin
                    priority if (i_stat.p_lt_q) n_act = sjsm_pkg::ACT_P;
                    else if (i_stat.q_lt_p)     n_act = sjsm_pkg::ACT_Q;
                    else                        n_act = sjsm_pkg::ACT_BOTH;
                end else if (i_stat.p_full && i_stat.q_fin) begin
                    n_act = sjsm_pkg::ACT_P;
                end else if (i_stat.q_full && i_stat.p_fin) begin
                    n_act = sjsm_pkg::ACT_Q;
                end else begin
                    n_state = sjsm_pkg::S_DIFF;
                end
            end
            sjsm_pkg::S_LOAD: begin
                o_cmd.norm_load = 1'b1;
                n_cnt   = '0;
                n_state = sjsm_pkg::S_NORM;
            end
            sjsm_pkg::S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (r_cnt == sjsm_pkg::CNT_W'(sjsm_pkg::NORM_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = sjsm_pkg::S_SQR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sjsm_pkg::S_SQR: begin
                o_cmd.sqr_step = 1'b1;
                if (r_cnt == sjsm_pkg::CNT_W'(sjsm_pkg::SQR_STEPS - 1)) begin
                    n_j     = job_first_j;
                    n_state = sjsm_pkg::S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sjsm_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sjsm_pkg::S_SUM;
            end
            sjsm_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = sjsm_pkg::S_ACC;
            end
            sjsm_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                priority if (!r_j && job_two_j) begin
                    n_j     = 1'b1;
                    n_state = sjsm_pkg::S_MUL;
                end else if (job_last) begin
                    n_state = sjsm_pkg::S_CLEAR;
                end else begin
                    n_job   = r_job + 1'b1;
                    n_state = sjsm_pkg::S_LOAD;
                end
            end
            sjsm_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_merges    = r_merges + 1'b1;
                n_state     = sjsm_pkg::S_DECIDE;
            end
            sjsm_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = sjsm_pkg::S_FIN;
            end
            sjsm_pkg::S_FIN: begin
                // Wait until the output register is free for the result.
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = sjsm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sjsm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sjsm_dp.sv =====
// Datapath of the sparse Jensen-Shannon merge unit: slots, log2 unit,
// term multiplier, accumulators and output register. Depends on sjsm_pkg.
module sjsm_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sjsm_pkg::t_cmd              i_cmd,
    output sjsm_pkg::t_stat             o_stat,
    input  logic [1:0]                  i_kind,
    input  logic [sjsm_pkg::KEY_W-1:0]  i_feature_key,
    input  logic [sjsm_pkg::VAL_W-1:0]  i_feature_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_need_p,
    output logic                        o_need_q,
    output logic                        o_order_error,
    output logic                        o_done_res,
    output logic [31:0]                 o_divergence
);

    localparam logic [sjsm_pkg::LOG_W-1:0] NL_J0 =
        sjsm_pkg::LOG_W'(sjsm_pkg::VAL_W) << sjsm_pkg::FRAC_W;
    localparam logic [sjsm_pkg::LOG_W-1:0] NL_J1 =
        sjsm_pkg::LOG_W'(sjsm_pkg::VAL_W + 1) << sjsm_pkg::FRAC_W;

    // Slot and stream state.
    logic [sjsm_pkg::KEY_W-1:0]   r_p_key, r_q_key;
    logic [sjsm_pkg::VAL_W-1:0]   r_p_val, r_q_val;
    logic                         r_p_full, r_q_full, r_p_fin, r_q_fin, r_err;
    logic [sjsm_pkg::ACC_W-1:0]   r_mix, r_pent, r_qent, r_d1;

    // Log2 and term registers.
    logic [sjsm_pkg::OPND_W-1:0]  r_x;
    logic [sjsm_pkg::EXP_W-1:0]   r_e;
    logic [sjsm_pkg::FRAC_W-1:0]  r_f;
    logic [sjsm_pkg::HP_W-1:0]    r_hp;
    logic [sjsm_pkg::LOG_W-1:0]   r_lp;
    logic [sjsm_pkg::TERM_W-1:0]  r_t;

    // Output register.
    logic        r_out_vld, r_need_p, r_need_q, r_oerr, r_done;
    logic [31:0] r_div;

    logic [sjsm_pkg::OPND_W-1:0]    opnd;
    logic [4:0]                     shamt;
    logic                           top_zero;
    logic [sjsm_pkg::VAL_W-1:0]     mant;
    logic [2*sjsm_pkg::VAL_W-1:0]   sq;
    logic [sjsm_pkg::OPND_W-1:0]    sq_sh;
    logic [sjsm_pkg::LOG_W-1:0]     nl;
    logic [sjsm_pkg::FRAC_W+sjsm_pkg::LOG_W-1:0] lo_prod;
    logic [sjsm_pkg::ACC_W:0]       sum_p, sum_q, sum_m;
    logic [sjsm_pkg::ACC_W-1:0]     sat_p, sat_q, sat_m;
    logic [sjsm_pkg::ACC_W-1:0]     d2;
    logic [sjsm_pkg::ACC_W-1:0]     half;
    logic                           done_now;
    logic                           acc_p, acc_q, acc_m;

    // Operand of the current term.
    always_comb begin
        unique case (i_cmd.opnd)
            sjsm_pkg::OPND_P:   opnd = {1'b0, r_p_val};
            sjsm_pkg::OPND_Q:   opnd = {1'b0, r_q_val};
            default:            opnd = {1'b0, r_p_val} + {1'b0, r_q_val};
        endcase
    end

    // One normalization step: shift left when the top bits are all zero.
    always_comb begin
        unique case (i_cmd.norm_idx)
            3'd0:    begin shamt = 5'd16; top_zero = (r_x[32:17] == '0); end
            3'd1:    begin shamt = 5'd8;  top_zero = (r_x[32:25] == '0); end
            3'd2:    begin shamt = 5'd4;  top_zero = (r_x[32:29] == '0); end
            3'd3:    begin shamt = 5'd2;  top_zero = (r_x[32:31] == '0); end
            default: begin shamt = 5'd1;  top_zero = !r_x[32];           end
        endcase
    end

    // One squaring step of the fractional log2 bits.
    assign mant  = r_x[sjsm_pkg::OPND_W-1:1];
    assign sq    = mant * mant;
    assign sq_sh = sq[2*sjsm_pkg::VAL_W-1:sjsm_pkg::VAL_W-1];

    // Negated log term weight and the low partial product.
    assign nl      = (i_cmd.j ? NL_J1 : NL_J0) - {r_e, r_f};
    assign lo_prod = opnd[sjsm_pkg::FRAC_W-1:0] * nl;

    // Saturating accumulation.
    assign sum_p = {1'b0, r_pent} + (sjsm_pkg::ACC_W+1)'(r_t);
    assign sum_q = {1'b0, r_qent} + (sjsm_pkg::ACC_W+1)'(r_t);
    assign sum_m = {1'b0, r_mix}  + (sjsm_pkg::ACC_W+1)'(r_t);
    assign sat_p = sum_p[sjsm_pkg::ACC_W] ? '1 : sum_p[sjsm_pkg::ACC_W-1:0];
    assign sat_q = sum_q[sjsm_pkg::ACC_W] ? '1 : sum_q[sjsm_pkg::ACC_W-1:0];
    assign sat_m = sum_m[sjsm_pkg::ACC_W] ? '1 : sum_m[sjsm_pkg::ACC_W-1:0];
    assign acc_m = i_cmd.acc && i_cmd.j;
    assign acc_p = i_cmd.acc && !i_cmd.j && (i_cmd.opnd == sjsm_pkg::OPND_P);
    assign acc_q = i_cmd.acc && !i_cmd.j && (i_cmd.opnd == sjsm_pkg::OPND_Q);

    // Final result: half the excess of the mixture entropy, saturated.
    assign d2       = (r_d1 > r_qent) ? (r_d1 - r_qent) : '0;
    assign half     = d2 >> 1;
    assign done_now = r_p_fin && r_q_fin && !r_p_full && !r_q_full;

    // Log2 unit and term multiplier registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_load) begin
            r_x <= opnd;
            r_e <= sjsm_pkg::EXP_W'(sjsm_pkg::VAL_W);
            r_f <= '0;
        end else if (i_cmd.norm_step) begin
            if (top_zero) begin
                r_x <= r_x << shamt;
                r_e <= r_e - sjsm_pkg::EXP_W'(shamt);
            end
        end else if (i_cmd.sqr_step) begin
            r_f <= {r_f[sjsm_pkg::FRAC_W-2:0], sq_sh[sjsm_pkg::OPND_W-1]};
            if (sq_sh[sjsm_pkg::OPND_W-1]) begin
                r_x <= {sq_sh[sjsm_pkg::OPND_W-1:1], 1'b0};
            end else begin
                r_x <= {sq_sh[sjsm_pkg::OPND_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_hp <= opnd[sjsm_pkg::OPND_W-1:sjsm_pkg::FRAC_W] * nl;
            r_lp <= lo_prod[sjsm_pkg::FRAC_W+sjsm_pkg::LOG_W-1:sjsm_pkg::FRAC_W];
        end
        if (i_cmd.sum) begin
            r_t <= sjsm_pkg::TERM_W'(r_hp) + sjsm_pkg::TERM_W'(r_lp);
        end
        if (i_cmd.diff) begin
            r_d1 <= (r_mix > r_pent) ? (r_mix - r_pent) : '0;
        end
    end

    // Slot payload is written on a record transfer into an open slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_feature_value != '0)) begin
            if ((i_kind == sjsm_pkg::KIND_P_REC) && !r_p_full && !r_p_fin) begin
                r_p_key <= i_feature_key;
                r_p_val <= i_feature_value;
            end
            if ((i_kind == sjsm_pkg::KIND_Q_REC) && !r_q_full && !r_q_fin) begin
                r_q_key <= i_feature_key;
                r_q_val <= i_feature_value;
            end
        end
    end

    // Slot flags, stream flags and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_full <= 1'b0;
            r_q_full <= 1'b0;
            r_p_fin  <= 1'b0;
            r_q_fin  <= 1'b0;
            r_err    <= 1'b0;
            r_mix    <= '0;
            r_pent   <= '0;
            r_qent   <= '0;
        end else begin
            if (i_cmd.load) begin
                unique case (i_kind)
                    sjsm_pkg::KIND_P_REC: begin
                        r_err <= r_p_full || r_p_fin;
                        if (!r_p_full && !r_p_fin && (i_feature_value != '0))
                            r_p_full <= 1'b1;
                    end
                    sjsm_pkg::KIND_Q_REC: begin
                        r_err <= r_q_full || r_q_fin;
                        if (!r_q_full && !r_q_fin && (i_feature_value != '0))
                            r_q_full <= 1'b1;
                    end
                    sjsm_pkg::KIND_P_END: begin
                        r_err   <= r_p_fin;
                        r_p_fin <= 1'b1;
                    end
                    default: begin
                        r_err   <= r_q_fin;
                        r_q_fin <= 1'b1;
                    end
                endcase
            end
            if (acc_p) r_pent <= sat_p;
            if (acc_q) r_qent <= sat_q;
            if (acc_m) r_mix  <= sat_m;
            if (i_cmd.clear) begin
                if (i_cmd.act != sjsm_pkg::ACT_Q) r_p_full <= 1'b0;
                if (i_cmd.act != sjsm_pkg::ACT_P) r_q_full <= 1'b0;
            end
            // A finished pair of streams clears the stream flags and the accumulators.
            if (i_cmd.finish && done_now) begin
                r_p_fin <= 1'b0;
                r_q_fin <= 1'b0;
                r_mix   <= '0;
                r_pent  <= '0;
                r_qent  <= '0;
            end
        end
    end

    // Output register, held until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_need_p <= done_now || (!r_p_full && !r_p_fin);
            r_need_q <= done_now || (!r_q_full && !r_q_fin);
            r_oerr   <= r_err;
            r_done   <= done_now;
            if (!done_now) begin
                r_div <= '0;
            end else if (half > sjsm_pkg::ACC_W'(32'hFFFF_FFFF)) begin
                r_div <= '1;
            end else begin
                r_div <= half[31:0];
            end
        end
    end

    assign o_stat.p_full   = r_p_full;
    assign o_stat.q_full   = r_q_full;
    assign o_stat.p_fin    = r_p_fin;
    assign o_stat.q_fin    = r_q_fin;
    assign o_stat.p_lt_q   = r_p_key < r_q_key;
    assign o_stat.q_lt_p   = r_q_key < r_p_key;
    assign o_stat.out_busy = r_out_vld && !i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_need_p      = r_need_p;
    assign o_need_q      = r_need_q;
    assign o_order_error = r_oerr;
    assign o_done_res    = r_done;
    assign o_divergence  = r_div;

endmodule

// ===== sv/sparse_jensen_shannon_merge_unit.sv =====
// Top level of the sparse Jensen-Shannon merge unit.
// Instantiates sjsm_ctrl and sjsm_dp; depends on sjsm_pkg and sjsm_if.
//
//  Channel  Dir  Payload                                          Handshake
//  i_req    in   kind, feature_key, feature_value                 valid/ready
//  o_res    out  need_p, need_q, order_error, done_res, divergence valid/ready
//
// One record at a time. An input passes through transfer, decide, difference and finish, plus
// its merges. One log2 term runs load, 6 normalize steps, 24 squaring steps on one 32x32
// multiplier, then multiply, sum and accumulate; a second weight repeats multiply, sum and
// accumulate; each merge adds a clear and a decide step. A lone record needs one term, equal
// keys three. Up to two merges follow each input. Reset is synchronous, active low, and empties
// slots, flags and accumulators. A waiting result lets the next record transfer; only the
// following result stalls until the waiting one is taken.
module sparse_jensen_shannon_merge_unit (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sjsm_in_if.sink    i_req,
    sjsm_out_if.source o_res
);

    sjsm_pkg::t_cmd  cmd;
    sjsm_pkg::t_stat stat;

    sjsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sjsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_req.kind),
        .i_feature_key   (i_req.feature_key),
        .i_feature_value (i_req.feature_value),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_need_p        (o_res.need_p),
        .o_need_q        (o_res.need_q),
        .o_order_error   (o_res.order_error),
        .o_done_res      (o_res.done_res),
        .o_divergence    (o_res.divergence)
    );

    // A finished pair of streams leaves both streams open for new records.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> o_res.need_p && o_res.need_q)
        else $error("done result without cleared streams");

    // Divergence is only reported with a finished pair of streams.
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.done_res |-> o_res.divergence == '0)
        else $error("divergence nonzero without done");

    // After a record transfer the block is busy with it.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("input ready right after a transfer");

endmodule
